// ----- hw/rtl/jde7s_pkg.sv -----
// Package for the joystick digit editor: register indexes, field widths,
// reset values and the seven-segment decode table. No dependencies.

package jde7s_pkg;

   // Width of one joystick sample field and of each configuration register
   localparam int SAMPLE_W = 10;
   localparam int REG_W    = 10;

   // Debounce counter saturates just above the largest debounce setting
   localparam int COUNT_W = REG_W + 1;
   localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(1 << REG_W);

   // Configuration register reset values
   localparam logic [REG_W-1:0] LOW_THRESHOLD_RESET  = 10'd400;
   localparam logic [REG_W-1:0] HIGH_THRESHOLD_RESET = 10'd600;
   localparam logic [REG_W-1:0] DEBOUNCE_MS_RESET    = 10'd50;

   // Digit range
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_DEBOUNCE_MS    = 2'd2
   } csr_index_type;

   // Segments a..g in bits 0..6, 1 lit; codes above nine are blank
   function automatic logic [6:0] seg_decode(input logic [3:0] digit);
      logic [6:0] seg;
      case (digit)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

// ----- hw/rtl/joystick_digit_editor_7seg.sv -----
// Top level of the joystick digit editor with multiplexed seven-segment scan.
// Depends on jde7s_pkg.
//
// Usage:
//   req_* carries one sample transaction: button level, joystick X and Y and a
//   millisecond tick. Every accepted request yields exactly one rsp_*
//   transaction with the scanned display enable, its segments and point, the
//   edit-mode flag and the selected display.
//   csr_* writes the low threshold, high threshold and debounce time; it is
//   always ready and must only be used while no request is in flight.
// Pipeline and throughput:
//   A request lands in the input register; when it advances, the debounce,
//   selection, digit edit and scan logic updates the state and loads the
//   response register. One request is accepted per cycle while the response
//   is not stalled; the single state-update stage sets that figure.
// Reset:
//   Synchronous, active high. Both registers empty, thresholds 400/600,
//   debounce 50 ms, all digits zero, all points dark, select mode.
// Stall:
//   A held response keeps its data; one more request waits in the input
//   register, after which req_tready drops until rsp_tready returns.

module joystick_digit_editor_7seg
   import jde7s_pkg::*;
#(
   parameter int DISPLAY_COUNT = 4,
   parameter int SAMPLE_BITS   = 10
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] button_level, [10:1] x_sample, [20:11] y_sample, [21] ms_tick, [23:22] zero
   input  logic [23:0] req_tdata,
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] digit_enable_n, [10:4] segment_bits, [11] point_on, [12] editing,
   // [14:13] chosen_display, [15] zero
   output logic [15:0] rsp_tdata,
   // Configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);

   localparam int SEL_W = (DISPLAY_COUNT > 1) ? $clog2(DISPLAY_COUNT) : 1;
   localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(DISPLAY_COUNT - 1);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

   // Configuration registers
   logic [REG_W-1:0] low_ff, high_ff, debounce_ff;

   // Input register
   logic                s1_valid_ff;
   logic                s1_button_ff;
   logic [SAMPLE_W-1:0] s1_x_ff, s1_y_ff;
   logic                s1_tick_ff;

   // Response register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff, rsp_data_in;

   // Editor state
   logic                prev_ff, prev_in;
   logic                stable_ff, stable_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                edit_ff, edit_in;
   logic [SEL_W-1:0]    sel_ff, sel_in;
   logic                y_block_ff, y_block_in;
   logic                x_block_ff, x_block_in;
   logic [SAMPLE_W-1:0] held_x_ff, held_x_in;
   logic [SEL_W-1:0]    pos_ff, pos_in;
   logic [DISPLAY_COUNT-1:0][3:0] digit_ff, digit_in;
   logic [DISPLAY_COUNT-1:0]      point_off_ff, point_off_in;

   logic advance;
   logic press_accept, press_toggle;
   logic step_dn, step_up, x_block_set;
   logic [3:0] shown_digit;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Configuration write transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= LOW_THRESHOLD_RESET;
         high_ff     <= HIGH_THRESHOLD_RESET;
         debounce_ff <= DEBOUNCE_MS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LOW_THRESHOLD:  low_ff      <= csr_data;
            CSR_HIGH_THRESHOLD: high_ff     <= csr_data;
            CSR_DEBOUNCE_MS:    debounce_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register; samples are masked to the converter width here
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_button_ff <= req_tdata[0];
         s1_x_ff      <= req_tdata[10:1] & SAMPLE_MASK;
         s1_y_ff      <= req_tdata[20:11] & SAMPLE_MASK;
         s1_tick_ff   <= req_tdata[21];
      end
   end

   // Single-pass state update for the item in the input register
   always_comb begin
      logic y_low, y_high, y_inside, hx_inside;

      // debounce
      prev_in = s1_button_ff;
      if (s1_button_ff != prev_ff) begin
         count_in = '0;
      end else if (s1_tick_ff && (count_ff != COUNT_SAT)) begin
         count_in = count_ff + COUNT_W'(1);
      end else begin
         count_in = count_ff;
      end
      press_accept = (count_in > {1'b0, debounce_ff}) && (s1_button_ff != stable_ff);
      stable_in    = press_accept ? s1_button_ff : stable_ff;
      press_toggle = press_accept && !s1_button_ff;
      edit_in      = edit_ff ^ press_toggle;

      // selection by Y
      y_low      = s1_y_ff < low_ff;
      y_high     = s1_y_ff > high_ff;
      sel_in     = sel_ff;
      y_block_in = y_block_ff;
      if (!edit_in && !y_block_ff) begin
         if (y_low) begin
            sel_in     = (sel_ff == LAST_SEL) ? '0 : sel_ff + SEL_W'(1);
            y_block_in = 1'b1;
         end else if (y_high) begin
            sel_in     = (sel_ff == '0) ? LAST_SEL : sel_ff - SEL_W'(1);
            y_block_in = 1'b1;
         end
      end

      // digit step by X
      held_x_in   = edit_in ? s1_x_ff : held_x_ff;
      step_dn     = edit_in && !x_block_ff && (s1_x_ff < low_ff);
      step_up     = edit_in && !x_block_ff && !(s1_x_ff < low_ff) && (s1_x_ff > high_ff);
      x_block_set = x_block_ff || step_dn || step_up;

      // re-arm once back inside the thresholds
      y_inside   = (s1_y_ff >= low_ff) && (s1_y_ff <= high_ff);
      hx_inside  = (held_x_in >= low_ff) && (held_x_in <= high_ff);
      y_block_in = y_block_in && !y_inside;
      x_block_in = x_block_set && !hx_inside;

      // per-display digit and point lanes
      for (int i = 0; i < DISPLAY_COUNT; i++) begin
         digit_in[i]     = digit_ff[i];
         point_off_in[i] = point_off_ff[i];
         if (sel_in == SEL_W'(i)) begin
            if (step_dn) begin
               digit_in[i] = ((digit_ff[i] == 4'd0) || (digit_ff[i] > DIGIT_MAX)) ?
                             DIGIT_MAX : digit_ff[i] - 4'd1;
            end else if (step_up) begin
               digit_in[i] = (digit_ff[i] >= DIGIT_MAX) ? 4'd0 : digit_ff[i] + 4'd1;
            end
         end
         // point follows the new mode: lit in edit mode, dark in select mode
         if (press_toggle && (sel_ff == SEL_W'(i))) begin
            point_off_in[i] = edit_ff;
         end
      end

      // scan advance on a tick
      if (s1_tick_ff) begin
         pos_in = (pos_ff == LAST_SEL) ? '0 : pos_ff + SEL_W'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   // Scanned response from the updated state
   assign shown_digit = digit_in[pos_ff];

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[3:0]   = ~(4'b0001 << pos_ff);
      rsp_data_in[10:4]  = seg_decode(shown_digit);
      rsp_data_in[11]    = ~point_off_in[pos_ff];
      rsp_data_in[12]    = edit_in;
      rsp_data_in[14:13] = 2'(sel_in);
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Editor state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= 1'b0;
         stable_ff    <= 1'b0;
         count_ff     <= '0;
         edit_ff      <= 1'b0;
         sel_ff       <= '0;
         y_block_ff   <= 1'b0;
         x_block_ff   <= 1'b0;
         held_x_ff    <= '0;
         pos_ff       <= '0;
         digit_ff     <= '0;
         point_off_ff <= '1;
      end else if (advance) begin
         prev_ff      <= prev_in;
         stable_ff    <= stable_in;
         count_ff     <= count_in;
         edit_ff      <= edit_in;
         sel_ff       <= sel_in;
         y_block_ff   <= y_block_in;
         x_block_ff   <= x_block_in;
         held_x_ff    <= held_x_in;
         pos_ff       <= pos_in;
         digit_ff     <= digit_in;
         point_off_ff <= point_off_in;
      end
   end

endmodule

// ----- hw/rtl/jde7s_checker.sv -----
// Port-level checks for the joystick digit editor, bound to its top level.
// Depends on jde7s_pkg and joystick_digit_editor_7seg.

module jde7s_checker
   import jde7s_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Last delivered response: mode and selection
   logic       last_valid_ff;
   logic       last_edit_ff;
   logic [1:0] last_chosen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff  <= 1'b0;
         last_edit_ff   <= 1'b0;
         last_chosen_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_valid_ff  <= 1'b1;
         last_edit_ff   <= rsp_tdata[12];
         last_chosen_ff <= rsp_tdata[14:13];
      end
   end

   // No response is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // A stalled response holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // With no response waiting, a request can always enter
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty response register");

   // The selection cannot move while edit mode is kept
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && last_valid_ff && last_edit_ff && rsp_tdata[12]
      |-> rsp_tdata[14:13] == last_chosen_ff)
      else $error("selection moved in edit mode");

endmodule

bind joystick_digit_editor_7seg jde7s_checker u_jde7s_checker (.*);
